FILE: hdl/mbd_pkg.sv
package mbd_pkg;

  localparam int ButtonIndexW = 4;
  localparam int BounceTimeW = 8;
  localparam int DefaultButtonCount = 16;
  localparam int ApbAddrW = 2;
  localparam int ApbDataW = 32;

  localparam logic [BounceTimeW-1:0] BounceTimeReset = 8'd10;

  // Byte address of the bounce time register.
  localparam logic [ApbAddrW-1:0] RegBounceTimeAddr = 2'd0;

  typedef enum logic [1:0] {
    PhaseReleased = 2'd0,
    PhasePressed = 2'd1,
    PhaseBouncing = 2'd2
  } phase_e;

endpackage

FILE: hdl/multi_button_debouncer.sv
// Debouncer for a bank of push buttons, one raw pin sample per transaction.
// Input channel: button_index_i and pin_level_i with in_valid_i; the block
// drives in_stall_o. Output channel: debounced_level_o with out_valid_o; the
// receiver drives out_stall_i. Every input transaction yields exactly one
// output transaction, in order.
// A sample is captured in the input register, then the button's entry is
// read, updated and written back in the same cycle as the result is loaded
// into the output register. A new sample is taken every cycle unless
// in_stall_o is high; the per-button state is a small flip-flop array updated
// by a single read-modify-write per sample, so samples of the same button may
// follow each other directly.
// When the receiver stalls, the held result stays on the output, one more
// sample may still be taken into the input register, and after that
// in_stall_o rises until the output drains.
// Reset clears all buttons to released with zeroed run counters, sets the
// bounce time to 10 and empties both registers. The user must write the
// bounce time via APB only while no transaction is in flight; it is not enforced.
module multi_button_debouncer #(
  parameter int BUTTON_COUNT = mbd_pkg::DefaultButtonCount
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mbd_pkg::ButtonIndexW-1:0]   button_index_i,
  input  logic                               pin_level_i,

  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               debounced_level_o,

  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbd_pkg::ApbAddrW-1:0]       paddr,
  input  logic [mbd_pkg::ApbDataW-1:0]       pwdata,
  output logic [mbd_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import mbd_pkg::*;

  // Only indices that the index field can carry need storage.
  localparam int IndexRange = 2 ** ButtonIndexW;
  localparam int EntryCount = (BUTTON_COUNT < IndexRange) ? BUTTON_COUNT : IndexRange;
  localparam int EntryIdxW = (EntryCount > 1) ? $clog2(EntryCount) : 1;

  // Configuration register.
  logic [BounceTimeW-1:0] bounce_time_q;
  logic                   cfg_write;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == RegBounceTimeAddr);
  assign prdata = (paddr == RegBounceTimeAddr) ?
                  ApbDataW'(bounce_time_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_time_q <= BounceTimeReset;
    end else if (cfg_write) begin
      bounce_time_q <= pwdata[BounceTimeW-1:0];
    end
  end

  // Input register.
  logic                    in_valid_q;
  logic [ButtonIndexW-1:0] button_index_q;
  logic                    pin_level_q;
  logic                    out_free;
  logic                    advance;
  logic                    in_take;

  assign out_free = !out_valid_o || !out_stall_i;
  assign advance = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      button_index_q <= button_index_i;
      pin_level_q <= pin_level_i;
    end
  end

  // Per-button state.
  phase_e                 phase_q [EntryCount];
  logic                   stable_q [EntryCount];
  logic [BounceTimeW-1:0] high_run_q [EntryCount];
  logic [BounceTimeW-1:0] low_run_q [EntryCount];

  logic                   in_range;
  logic [EntryIdxW-1:0]   entry_idx;
  phase_e                 phase_cur;
  logic                   stable_cur;
  logic [BounceTimeW-1:0] high_cur;
  logic [BounceTimeW-1:0] low_cur;
  phase_e                 phase_d;
  logic                   stable_d;
  logic [BounceTimeW-1:0] high_d;
  logic [BounceTimeW-1:0] low_d;
  logic                   result_d;

  assign in_range = 32'(button_index_q) < BUTTON_COUNT;
  assign entry_idx = button_index_q[EntryIdxW-1:0];
  assign phase_cur = phase_q[entry_idx];
  assign stable_cur = stable_q[entry_idx];
  assign high_cur = high_run_q[entry_idx];
  assign low_cur = low_run_q[entry_idx];

  always_comb begin
    phase_d = phase_cur;
    stable_d = stable_cur;
    high_d = high_cur;
    low_d = low_cur;
    result_d = 1'b0;
    unique case (phase_cur)
      PhasePressed: begin
        if (!pin_level_q) begin
          phase_d = PhaseBouncing;
          stable_d = 1'b1;
        end
        result_d = 1'b1;
      end
      PhaseBouncing: begin
        if (pin_level_q) begin
          low_d = '0;
          high_d = high_cur + 1'b1;
        end else begin
          high_d = '0;
          low_d = low_cur + 1'b1;
        end
        result_d = stable_cur;
        // The high run is checked first; only one run can be nonzero anyway.
        if (high_d == bounce_time_q) begin
          phase_d = PhasePressed;
          high_d = '0;
          result_d = 1'b1;
        end else if (low_d == bounce_time_q) begin
          phase_d = PhaseReleased;
          low_d = '0;
          result_d = 1'b0;
        end
      end
      default: begin
        // Released, and the unused phase code, which behaves the same.
        if (pin_level_q) begin
          phase_d = PhaseBouncing;
          stable_d = 1'b0;
        end
        result_d = 1'b0;
      end
    endcase
    // Samples for buttons that do not exist leave no trace and read as released.
    if (!in_range) begin
      result_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < EntryCount; i++) begin
        phase_q[i] <= PhaseReleased;
        stable_q[i] <= 1'b0;
        high_run_q[i] <= '0;
        low_run_q[i] <= '0;
      end
    end else if (advance && in_range) begin
      phase_q[entry_idx] <= phase_d;
      stable_q[entry_idx] <= stable_d;
      high_run_q[entry_idx] <= high_d;
      low_run_q[entry_idx] <= low_d;
    end
  end

  // Output register.
  logic out_valid_q;
  logic result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign debounced_level_o = result_q;

endmodule

FILE: sim/tb_multi_button_debouncer.sv
`timescale 1ns / 1ps

module tb_multi_button_debouncer;
  import mbd_pkg::*;

  localparam int Buttons = DefaultButtonCount;
  localparam int LongHoldCycles = 40;
  localparam int SettleCycles = 4;
  localparam int MaxReported = 10;
  localparam int unsigned TimeoutNs = 5_000_000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [ButtonIndexW-1:0] button_index_i = '0;
  logic                    pin_level_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic                    debounced_level_o;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ApbAddrW-1:0]     paddr = '0;
  logic [ApbDataW-1:0]     pwdata = '0;
  logic [ApbDataW-1:0]     prdata;
  logic                    pready;

  // Shadow copy of the per-button debounce state.
  phase_e                 btn_phase [Buttons];
  logic                   stable_lvl [Buttons];
  logic [BounceTimeW-1:0] high_run [Buttons];
  logic [BounceTimeW-1:0] low_run [Buttons];
  logic [BounceTimeW-1:0] bounce_cfg = BounceTimeReset;

  logic debounced_q [$];
  int   error_cnt = 0;
  int   sample_cnt = 0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  int   hold_req_cnt = 0;
  int   hold_ack_cnt = 0;
  int   hold_left = 0;
  int   stall_left = 0;

  multi_button_debouncer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .button_index_i   (button_index_i),
    .pin_level_i      (pin_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .debounced_level_o(debounced_level_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    for (int b = 0; b < Buttons; b++) begin
      btn_phase[b] = PhaseReleased;
      stable_lvl[b] = 1'b0;
      high_run[b] = '0;
      low_run[b] = '0;
    end
  end

  function automatic logic debounce_sample(input logic [ButtonIndexW-1:0] idx, input logic lvl);
    logic lvl_out;
    lvl_out = 1'b0;
    case (btn_phase[idx])
      PhasePressed: begin
        if (!lvl) begin
          btn_phase[idx] = PhaseBouncing;
          stable_lvl[idx] = 1'b1;
        end
        lvl_out = 1'b1;
      end
      PhaseBouncing: begin
        if (lvl) begin
          low_run[idx] = '0;
          high_run[idx] = high_run[idx] + 8'd1;
        end else begin
          high_run[idx] = '0;
          low_run[idx] = low_run[idx] + 8'd1;
        end
        lvl_out = stable_lvl[idx];
        // The high run is checked first; with a bounce time of zero the run
        // that was just cleared matches, so the button flips to the other level.
        if (high_run[idx] == bounce_cfg) begin
          btn_phase[idx] = PhasePressed;
          high_run[idx] = '0;
          lvl_out = 1'b1;
        end else if (low_run[idx] == bounce_cfg) begin
          btn_phase[idx] = PhaseReleased;
          low_run[idx] = '0;
          lvl_out = 1'b0;
        end
      end
      default: begin
        if (lvl) begin
          btn_phase[idx] = PhaseBouncing;
          stable_lvl[idx] = 1'b0;
        end
        lvl_out = 1'b0;
      end
    endcase
    return lvl_out;
  endfunction

  function automatic void log_error(input string what);
    if (error_cnt < MaxReported) $display("ERROR: %s at %0t ns", what, $time);
    error_cnt++;
  endfunction

  // Output side stall: a requested long hold takes priority over random bursts.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_ack_cnt) begin
      hold_ack_cnt <= hold_req_cnt;
      hold_left <= LongHoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    logic want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (debounced_q.size() == 0) begin
        log_error($sformatf("unexpected transaction, debounced_level %0b", debounced_level_o));
      end else begin
        want = debounced_q.pop_front();
        if (debounced_level_o !== want)
          log_error($sformatf("debounced_level expected %0b got %0b", want, debounced_level_o));
      end
    end
  end

  task automatic send_sample(input logic [ButtonIndexW-1:0] idx, input logic lvl);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    button_index_i <= idx;
    pin_level_i <= lvl;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    debounced_q.push_back(debounce_sample(idx, lvl));
    sample_cnt++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (debounced_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_bounce_time(input logic [BounceTimeW-1:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RegBounceTimeAddr;
    pwdata <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bounce_cfg = value;
    @(posedge clk_i);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 4) == 0)
      send_sample(ButtonIndexW'($urandom_range(0, Buttons - 1)), 1'($urandom_range(0, 1)));
  endtask

  // A press or release: a few random glitches, then a steady run near the bounce time.
  task automatic run_sequence(input logic [ButtonIndexW-1:0] btn, input logic target);
    int glitches;
    int run_len;
    glitches = $urandom_range(0, 4);
    run_len = int'(bounce_cfg) - 1 + $urandom_range(0, 2);
    if (run_len < 1) run_len = 1;
    repeat (glitches) begin
      send_noise();
      send_sample(btn, 1'($urandom_range(0, 1)));
    end
    repeat (run_len) begin
      send_noise();
      send_sample(btn, target);
    end
  endtask

  task automatic run_phase(input int count);
    int start;
    start = sample_cnt;
    while (sample_cnt - start < count)
      run_sequence(ButtonIndexW'($urandom_range(0, Buttons - 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_reset_bounce_time();
    send_sample(4'd0, 1'b1);
    repeat (10) send_sample(4'd0, 1'b1);
    send_sample(4'd7, 1'b0);
    send_sample(4'd15, 1'b1);
    send_sample(4'd15, 1'b0);
  endtask

  task automatic test_min_bounce_time();
    set_bounce_time(8'd1);
    send_sample(4'd15, 1'b1);
    send_sample(4'd15, 1'b0);
    send_sample(4'd15, 1'b0);
    send_sample(4'd0, 1'b1);
    send_sample(4'd8, 1'b1);
    send_sample(4'd8, 1'b0);
  endtask

  // A long run under the maximum bounce time, then a lower bounce time makes
  // the run counter wrap before it matches.
  task automatic test_counter_wrap();
    set_bounce_time(8'd255);
    send_sample(4'd0, 1'b0);
    repeat (200) send_sample(4'd0, 1'b0);
    set_bounce_time(8'd5);
    repeat (62) send_sample(4'd0, 1'b0);
  endtask

  task automatic test_zero_bounce_time();
    set_bounce_time(8'd0);
    repeat (16)
      send_sample(ButtonIndexW'($urandom_range(2, 4)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_output_backpressure();
    set_bounce_time(BounceTimeW'($urandom_range(2, 16)));
    tx_idle_on = 1'b0;
    hold_req_cnt++;
    repeat (30)
      send_sample(ButtonIndexW'($urandom_range(0, Buttons - 1)), 1'($urandom_range(0, 1)));
    drain_results();
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_presses();
    set_bounce_time(8'd3);
    run_phase(150);
    drain_results();
    run_phase(150);
    set_bounce_time(8'd255);
    repeat (2)
      run_sequence(ButtonIndexW'($urandom_range(0, Buttons - 1)), 1'($urandom_range(0, 1)));
    set_bounce_time(BounceTimeW'($urandom_range(2, 12)));
    run_phase(200);
    drain_results();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_bounce_time(8'd1);
    run_phase(150);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_bounce_time();
    test_min_bounce_time();
    test_counter_wrap();
    test_zero_bounce_time();
    test_output_backpressure();
    test_random_presses();
    drain_results();
    if (error_cnt == 0 && debounced_q.size() == 0) begin
      $display("multi_button_debouncer verification clean");
    end else begin
      $display("multi_button_debouncer verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("multi_button_debouncer verification failed");
    $finish;
  end

endmodule
